@@ src/dcf_pkg.sv @@
// ----------------------------------------------------------------------------
// dcf_pkg
// Types, constants and Q16.16 arithmetic helpers shared by the contact force
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dcf_pkg;

    localparam int Q_W         = 32;
    localparam int R_W         = 31;
    localparam int IDX_W       = 14;
    localparam int KN_W        = 16;
    localparam int CF_W        = 8;
    localparam int BASE_W      = 15;
    localparam int K_W         = 24;
    localparam int CFG_DATA_W  = 31;
    localparam int CFG_INDEX_W = 3;
    localparam int NUM_STAGES  = 8;

    typedef logic signed [Q_W-1:0] q_t;
    typedef logic [R_W-1:0]        ufix_t;
    typedef logic [K_W-1:0]        stiff_t;

    localparam q_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q_t Q_MIN = 32'sh8000_0000;

    localparam logic [BASE_W-1:0] MAX_PARTICLES = 15'd16384;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_NORMAL_STIFFNESS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STIFFNESS_FACTOR = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_COUNT       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DAMPING          = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRICTION_COEFF   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIME_STEP        = 3'd5;

    localparam logic [KN_W-1:0]   KN_RESET   = 16'd1000;
    localparam logic [CF_W-1:0]   CF_RESET   = 8'd10;
    localparam logic [BASE_W-1:0] BASE_RESET = 15'd0;
    localparam ufix_t             DAMP_RESET = 31'd0;
    localparam ufix_t             MU_RESET   = 31'd32768;
    localparam ufix_t             DT_RESET   = 31'd66;
    localparam stiff_t K_BOTH_RESET  = 24'd10000;
    localparam stiff_t K_MIXED_RESET = 24'd5500;

    typedef struct packed {
        logic [IDX_W-1:0] index_i;
        logic [IDX_W-1:0] index_j;
        q_t               overlap;
        q_t               normal_x;
        q_t               normal_y;
        q_t               rel_vel_x;
        q_t               rel_vel_y;
        q_t               spin_i;
        q_t               spin_j;
        ufix_t            radius_i;
        ufix_t            radius_j;
        q_t               prev_tangential;
    } contact_t;

    typedef struct packed {
        q_t   normal_force;
        q_t   tangential_force;
        q_t   force_x;
        q_t   force_y;
        q_t   torque_i;
        q_t   torque_j;
        logic slipping;
    } result_t;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [KN_W-1:0]   kn;
        stiff_t            k_both;
        stiff_t            k_mixed;
        logic [BASE_W-1:0] base;
        ufix_t             damp;
        ufix_t             mu;
        ufix_t             dt;
    } cfg_t;

    function automatic logic signed [63:0] ext(input q_t a);
        return 64'(a);
    endfunction

    function automatic q_t to_q(input ufix_t u);
        return q_t'({1'b0, u});
    endfunction

    function automatic q_t sat_q(input logic signed [63:0] v);
        if (v[63:Q_W-1] == '0 || v[63:Q_W-1] == '1)
            return q_t'(v[Q_W-1:0]);
        else if (v[63])
            return Q_MIN;
        else
            return Q_MAX;
    endfunction

    // Q16.16 product, floor rounding, saturated
    function automatic q_t qmul(input q_t a, input q_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat_q(p >>> 16);
    endfunction

    // Q16.16 value times integer stiffness, full width
    function automatic logic signed [63:0] mul_k(input q_t a, input stiff_t k);
        logic signed [K_W:0] ks;
        ks = signed'({1'b0, k});
        return 64'(a) * 64'(ks);
    endfunction

endpackage

`default_nettype wire

@@ src/dcf_cfg.sv @@
// ----------------------------------------------------------------------------
// dcf_cfg
// Configuration registers and the precomputed stiffness of added and mixed
// particle pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module dcf_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [dcf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [dcf_pkg::CFG_DATA_W-1:0]   cfg_data,
    output dcf_pkg::cfg_t                         cfg
);
    import dcf_pkg::*;

    logic [KN_W-1:0]   kn_reg;
    logic [CF_W-1:0]   cf_reg;
    logic [BASE_W-1:0] base_reg;
    logic [BASE_W-1:0] base_next;
    ufix_t             damp_reg;
    ufix_t             mu_reg;
    ufix_t             dt_reg;
    stiff_t            k_both_reg;
    stiff_t            k_both_next;
    stiff_t            k_mixed_reg;
    stiff_t            k_mixed_next;

    always_comb
    begin
        if (cfg_data[BASE_W-1:0] > MAX_PARTICLES)
            base_next = MAX_PARTICLES;
        else
            base_next = cfg_data[BASE_W-1:0];
        k_both_next  = K_W'(kn_reg) * K_W'(cf_reg);
        k_mixed_next = (K_W'(kn_reg) * (K_W'(cf_reg) + K_W'(1))) >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kn_reg      <= KN_RESET;
            cf_reg      <= CF_RESET;
            base_reg    <= BASE_RESET;
            damp_reg    <= DAMP_RESET;
            mu_reg      <= MU_RESET;
            dt_reg      <= DT_RESET;
            k_both_reg  <= K_BOTH_RESET;
            k_mixed_reg <= K_MIXED_RESET;
        end
        else
        begin
            // derived stiffness follows the registers in the next cycle
            k_both_reg  <= k_both_next;
            k_mixed_reg <= k_mixed_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_NORMAL_STIFFNESS: kn_reg   <= cfg_data[KN_W-1:0];
                    CFG_STIFFNESS_FACTOR: cf_reg   <= cfg_data[CF_W-1:0];
                    CFG_BASE_COUNT:       base_reg <= base_next;
                    CFG_DAMPING:          damp_reg <= cfg_data[R_W-1:0];
                    CFG_FRICTION_COEFF:   mu_reg   <= cfg_data[R_W-1:0];
                    CFG_TIME_STEP:        dt_reg   <= cfg_data[R_W-1:0];
                    default:              ;
                endcase
            end
        end
    end

    assign cfg.kn      = kn_reg;
    assign cfg.k_both  = k_both_reg;
    assign cfg.k_mixed = k_mixed_reg;
    assign cfg.base    = base_reg;
    assign cfg.damp    = damp_reg;
    assign cfg.mu      = mu_reg;
    assign cfg.dt      = dt_reg;

endmodule

`default_nettype wire

@@ src/dcf_pipe_ctrl.sv @@
// ----------------------------------------------------------------------------
// dcf_pipe_ctrl
// Valid bits and per-stage load enables; a stage loads when it is empty or
// its successor loads, so bubbles close up under a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module dcf_pipe_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [dcf_pkg::NUM_STAGES-1:0]       stage_en
);
    import dcf_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;

    always_comb
    begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int s = NUM_STAGES - 2; s >= 0; s--)
            stage_en[s] = !valid_reg[s] || stage_en[s+1];

        valid_next[0] = stage_en[0] ? in_valid : valid_reg[0];
        for (int s = 1; s < NUM_STAGES; s++)
            valid_next[s] = stage_en[s] ? valid_reg[s-1] : valid_reg[s];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

endmodule

`default_nettype wire

@@ src/dcf_datapath.sv @@
// ----------------------------------------------------------------------------
// dcf_datapath
// Eight register stages of the contact force: products, sums, stiffness,
// friction cap, force vector and torques.
// ----------------------------------------------------------------------------
`default_nettype none

module dcf_datapath (
    input  wire logic                        clk,
    input  wire dcf_pkg::cfg_t               cfg,
    input  wire logic [dcf_pkg::NUM_STAGES-1:0] stage_en,
    input  wire dcf_pkg::contact_t           contact,
    output dcf_pkg::result_t                 result
);
    import dcf_pkg::*;

    typedef struct packed {
        q_t    p_nvx;
        q_t    p_nvy;
        q_t    p_tvx;
        q_t    p_tvy;
        q_t    p_wri;
        q_t    p_wrj;
        logic  added_i;
        logic  added_j;
        q_t    overlap;
        q_t    nx;
        q_t    ny;
        q_t    tx;
        ufix_t ri;
        ufix_t rj;
        q_t    prev;
    } b_t;

    typedef struct packed {
        q_t     vn;
        q_t     vt;
        stiff_t k;
        q_t     overlap;
        q_t     nx;
        q_t     ny;
        q_t     tx;
        ufix_t  ri;
        ufix_t  rj;
        q_t     prev;
    } c_t;

    typedef struct packed {
        q_t     fnel;
        q_t     fnvi;
        q_t     d;
        stiff_t ks;
        q_t     nx;
        q_t     ny;
        q_t     tx;
        ufix_t  ri;
        ufix_t  rj;
        q_t     prev;
    } d_t;

    typedef struct packed {
        q_t    fn;
        q_t    ksd;
        q_t    lim;
        q_t    nx;
        q_t    ny;
        q_t    tx;
        ufix_t ri;
        ufix_t rj;
        q_t    prev;
    } e_t;

    typedef struct packed {
        q_t    fn;
        q_t    ft;
        logic  slip;
        q_t    nx;
        q_t    ny;
        q_t    tx;
        ufix_t ri;
        ufix_t rj;
    } f_t;

    typedef struct packed {
        q_t   p_fnx;
        q_t   p_ftx;
        q_t   p_fny;
        q_t   p_fty;
        q_t   p_fri;
        q_t   p_frj;
        q_t   fn;
        q_t   ft;
        logic slip;
    } g_t;

    contact_t a_reg;
    b_t       b_reg, b_next;
    c_t       c_reg, c_next;
    d_t       d_reg, d_next;
    e_t       e_reg, e_next;
    f_t       f_reg, f_next;
    g_t       g_reg, g_next;
    result_t  out_reg, out_next;

    // stage A: tangent, first products, particle class
    always_comb
    begin
        q_t tx;
        tx = sat_q(-ext(a_reg.normal_y));
        b_next.p_nvx   = qmul(a_reg.normal_x, a_reg.rel_vel_x);
        b_next.p_nvy   = qmul(a_reg.normal_y, a_reg.rel_vel_y);
        b_next.p_tvx   = qmul(tx, a_reg.rel_vel_x);
        b_next.p_tvy   = qmul(a_reg.normal_x, a_reg.rel_vel_y);
        b_next.p_wri   = qmul(a_reg.spin_i, to_q(a_reg.radius_i));
        b_next.p_wrj   = qmul(a_reg.spin_j, to_q(a_reg.radius_j));
        b_next.added_i = {1'b0, a_reg.index_i} >= cfg.base;
        b_next.added_j = {1'b0, a_reg.index_j} >= cfg.base;
        b_next.overlap = a_reg.overlap;
        b_next.nx      = a_reg.normal_x;
        b_next.ny      = a_reg.normal_y;
        b_next.tx      = tx;
        b_next.ri      = a_reg.radius_i;
        b_next.rj      = a_reg.radius_j;
        b_next.prev    = a_reg.prev_tangential;
    end

    // stage B: normal and slip velocity, stiffness select
    always_comb
    begin
        c_next.vn = sat_q(ext(b_reg.p_nvx) + ext(b_reg.p_nvy));
        c_next.vt = sat_q(ext(b_reg.p_tvx) + ext(b_reg.p_tvy)
                          - ext(b_reg.p_wri) - ext(b_reg.p_wrj));
        if (b_reg.added_i && b_reg.added_j)
            c_next.k = cfg.k_both;
        else if (b_reg.added_i || b_reg.added_j)
            c_next.k = cfg.k_mixed;
        else
            c_next.k = K_W'(cfg.kn);
        c_next.overlap = b_reg.overlap;
        c_next.nx      = b_reg.nx;
        c_next.ny      = b_reg.ny;
        c_next.tx      = b_reg.tx;
        c_next.ri      = b_reg.ri;
        c_next.rj      = b_reg.rj;
        c_next.prev    = b_reg.prev;
    end

    // stage C: elastic and damping force, displacement, ks = floor(3k/4)
    always_comb
    begin
        logic [K_W+1:0] k3;
        k3 = {2'b00, c_reg.k} + {1'b0, c_reg.k, 1'b0};
        d_next.fnel = sat_q(-mul_k(c_reg.overlap, c_reg.k));
        d_next.fnvi = sat_q(-ext(qmul(c_reg.vn, to_q(cfg.damp))));
        d_next.d    = qmul(c_reg.vt, to_q(cfg.dt));
        d_next.ks   = k3[K_W+1:2];
        d_next.nx   = c_reg.nx;
        d_next.ny   = c_reg.ny;
        d_next.tx   = c_reg.tx;
        d_next.ri   = c_reg.ri;
        d_next.rj   = c_reg.rj;
        d_next.prev = c_reg.prev;
    end

    // stage D: total normal force, spring term, friction limit
    always_comb
    begin
        e_next.fn   = sat_q(ext(d_reg.fnel) + ext(d_reg.fnvi));
        e_next.ksd  = sat_q(mul_k(d_reg.d, d_reg.ks));
        e_next.lim  = qmul(to_q(cfg.mu), d_reg.fnel);
        e_next.nx   = d_reg.nx;
        e_next.ny   = d_reg.ny;
        e_next.tx   = d_reg.tx;
        e_next.ri   = d_reg.ri;
        e_next.rj   = d_reg.rj;
        e_next.prev = d_reg.prev;
    end

    // stage E: trial force and Coulomb cap
    always_comb
    begin
        q_t                 trial;
        logic signed [63:0] wide;
        logic signed [63:0] mag;
        trial = sat_q(ext(e_reg.prev) - ext(e_reg.ksd));
        wide  = ext(trial);
        mag   = wide[63] ? -wide : wide;
        f_next.slip = mag > ext(e_reg.lim);
        if (!f_next.slip)
            f_next.ft = trial;
        else if (trial > 0)
            f_next.ft = e_reg.lim;
        else
            f_next.ft = sat_q(-ext(e_reg.lim));
        f_next.fn = e_reg.fn;
        f_next.nx = e_reg.nx;
        f_next.ny = e_reg.ny;
        f_next.tx = e_reg.tx;
        f_next.ri = e_reg.ri;
        f_next.rj = e_reg.rj;
    end

    // stage F: projection and lever-arm products
    always_comb
    begin
        g_next.p_fnx = qmul(f_reg.fn, f_reg.nx);
        g_next.p_ftx = qmul(f_reg.ft, f_reg.tx);
        g_next.p_fny = qmul(f_reg.fn, f_reg.ny);
        g_next.p_fty = qmul(f_reg.ft, f_reg.nx);
        g_next.p_fri = qmul(f_reg.ft, to_q(f_reg.ri));
        g_next.p_frj = qmul(f_reg.ft, to_q(f_reg.rj));
        g_next.fn    = f_reg.fn;
        g_next.ft    = f_reg.ft;
        g_next.slip  = f_reg.slip;
    end

    // stage G: output word
    always_comb
    begin
        out_next.normal_force     = g_reg.fn;
        out_next.tangential_force = g_reg.ft;
        out_next.force_x          = sat_q(ext(g_reg.p_fnx) + ext(g_reg.p_ftx));
        out_next.force_y          = sat_q(ext(g_reg.p_fny) + ext(g_reg.p_fty));
        out_next.torque_i         = sat_q(-ext(g_reg.p_fri));
        out_next.torque_j         = sat_q(-ext(g_reg.p_frj));
        out_next.slipping         = g_reg.slip;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0]) a_reg   <= contact;
        if (stage_en[1]) b_reg   <= b_next;
        if (stage_en[2]) c_reg   <= c_next;
        if (stage_en[3]) d_reg   <= d_next;
        if (stage_en[4]) e_reg   <= e_next;
        if (stage_en[5]) f_reg   <= f_next;
        if (stage_en[6]) g_reg   <= g_next;
        if (stage_en[7]) out_reg <= out_next;
    end

    assign result = out_reg;

endmodule

`default_nettype wire

@@ src/dem_contact_force_friction.sv @@
// ----------------------------------------------------------------------------
// dem_contact_force_friction
// Disc-disc spring-dashpot contact force with Coulomb friction, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   contact_valid/contact_ready/contact carry one contact word per handshake;
//   result_valid/result_ready/result return one result word per contact, in
//   order. cfg_wr_en/cfg_index/cfg_data write a configuration register;
//   write only while no contact is in flight. Each contact passes through
//   eight register stages, the input register being the first, before its
//   result is shown on the result port.
//   Throughput: one contact per cycle while result_ready is high; the
//   contact_ready chain is set by the eight-stage valid pipeline.
//   A stall on result_ready holds the output word; upstream stages keep
//   filling until each one is occupied, then contact_ready drops.
//   Reset clears all valid bits and loads the register defaults
//   (normal stiffness 1000, factor 10, base count 0, damping 0,
//   friction 0.5, time step 66/65536). Base count writes above the
//   particle limit are clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module dem_contact_force_friction (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [dcf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [dcf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                             contact_valid,
    output logic                                  contact_ready,
    input  wire dcf_pkg::contact_t                contact,
    output logic                                  result_valid,
    input  wire logic                             result_ready,
    output dcf_pkg::result_t                      result
);
    import dcf_pkg::*;

    cfg_t                  cfg;
    logic [NUM_STAGES-1:0] stage_en;

    dcf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dcf_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (contact_valid),
        .in_ready  (contact_ready),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .stage_en  (stage_en)
    );

    dcf_datapath u_dp (
        .clk      (clk),
        .cfg      (cfg),
        .stage_en (stage_en),
        .contact  (contact),
        .result   (result)
    );

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the disc-disc contact force block. A short table of
// directed contacts runs at the reset configuration, then several register
// settings follow, each with a run of random contacts. Every accepted contact
// is checked against its table word if typed, else against a local Q16.16
// model of the force pipeline, field by field and in arrival order. Both
// handshakes idle at random; one burst fills the pipe, result side held off.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import dcf_pkg::*;

    localparam longint FX_HI = 64'sd2147483647;
    localparam longint FX_LO = -64'sd2147483648;
    localparam q_t     ONE   = 32'sd65536;
    localparam ufix_t  R_MAX = '1;
    localparam int     IDX_MAX = 16383;
    localparam int     BASE_LIMIT = 16384;
    localparam int     LONG_HOLD = 150;
    localparam int     WATCHDOG_LIMIT = 1000;

    // indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        contact_t word;
        bit       typed;
        result_t  want;
    } table_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   contact_valid = 1'b0;
    logic                   contact_ready;
    contact_t               contact = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_t                result;

    // register shadow used by the force predictor
    longint kn_now   = KN_RESET;
    longint cf_now   = CF_RESET;
    longint base_now = BASE_RESET;
    longint damp_now = DAMP_RESET;
    longint mu_now   = MU_RESET;
    longint dt_now   = DT_RESET;

    result_t    expected_forces[$];
    table_row_t directed_rows[$];
    int         mismatch_count = 0;
    int         quiet_cycles = 0;
    int         burst_left = 0;
    bit         idle_on = 1'b1;
    bit         hold_pending = 1'b0;

    dem_contact_force_friction i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .contact_valid (contact_valid),
        .contact_ready (contact_ready),
        .contact       (contact),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Q16.16 force model
    // ------------------------------------------------------------------
    function automatic longint clamp_q(input longint v);
        if (v > FX_HI)
            return FX_HI;
        if (v < FX_LO)
            return FX_LO;
        return v;
    endfunction

    // exact product, floor to Q16.16, clamp
    function automatic longint fixed_mul(input longint a, input longint b);
        return clamp_q((a * b) >>> 16);
    endfunction

    function automatic result_t predict_contact_force(input contact_t c);
        longint  k, ks, ov, nx, ny, vx, vy, wi, wj, ri, rj, prev;
        longint  vn, fnel, fnvi, fn, tx, ty, vt, d, ft, lim, mag, fx, fy;
        bit      added_i, added_j, slip;
        result_t r;
        added_i = longint'(c.index_i) >= base_now;
        added_j = longint'(c.index_j) >= base_now;
        if (added_i && added_j)
            k = kn_now * cf_now;
        else if (added_i || added_j)
            k = (kn_now * (1 + cf_now)) / 2;
        else
            k = kn_now;
        ks = (3 * k) / 4;

        ov   = longint'(c.overlap);
        nx   = longint'(c.normal_x);
        ny   = longint'(c.normal_y);
        vx   = longint'(c.rel_vel_x);
        vy   = longint'(c.rel_vel_y);
        wi   = longint'(c.spin_i);
        wj   = longint'(c.spin_j);
        ri   = longint'({1'b0, c.radius_i});
        rj   = longint'({1'b0, c.radius_j});
        prev = longint'(c.prev_tangential);

        vn   = clamp_q(fixed_mul(nx, vx) + fixed_mul(ny, vy));
        fnel = clamp_q(-(ov * k));
        fnvi = clamp_q(-fixed_mul(vn, damp_now));
        fn   = clamp_q(fnel + fnvi);

        tx = clamp_q(-ny);
        ty = nx;
        vt = clamp_q(fixed_mul(tx, vx) + fixed_mul(ty, vy)
                     - fixed_mul(wi, ri) - fixed_mul(wj, rj));
        d  = fixed_mul(vt, dt_now);
        ft = clamp_q(prev - clamp_q(ks * d));

        // friction cap from the elastic part only
        lim  = fixed_mul(mu_now, fnel);
        mag  = (ft < 0) ? -ft : ft;
        slip = mag > lim;
        if (slip)
            ft = (ft > 0) ? lim : clamp_q(-lim);

        fx = clamp_q(fixed_mul(fn, nx) + fixed_mul(ft, tx));
        fy = clamp_q(fixed_mul(fn, ny) + fixed_mul(ft, ty));

        r.normal_force     = 32'(fn);
        r.tangential_force = 32'(ft);
        r.force_x          = 32'(fx);
        r.force_y          = 32'(fy);
        r.torque_i         = 32'(clamp_q(-fixed_mul(ft, ri)));
        r.torque_j         = 32'(clamp_q(-fixed_mul(ft, rj)));
        r.slipping         = slip;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic contact_t mk_contact(
        input int unsigned ii, input int unsigned jj, input q_t ov,
        input q_t nx, input q_t ny, input q_t vx, input q_t vy,
        input q_t wi, input q_t wj, input ufix_t ri, input ufix_t rj,
        input q_t pt);
        contact_t c;
        c.index_i         = IDX_W'(ii);
        c.index_j         = IDX_W'(jj);
        c.overlap         = ov;
        c.normal_x        = nx;
        c.normal_y        = ny;
        c.rel_vel_x       = vx;
        c.rel_vel_y       = vy;
        c.spin_i          = wi;
        c.spin_j          = wj;
        c.radius_i        = ri;
        c.radius_j        = rj;
        c.prev_tangential = pt;
        return c;
    endfunction

    function automatic result_t mk_result(input q_t fn, input q_t ft, input q_t fx,
                                          input q_t fy, input q_t ti, input q_t tj,
                                          input logic slip);
        result_t r;
        r.normal_force     = fn;
        r.tangential_force = ft;
        r.force_x          = fx;
        r.force_y          = fy;
        r.torque_i         = ti;
        r.torque_j         = tj;
        r.slipping         = slip;
        return r;
    endfunction

    // mostly moderate magnitudes, some full range, some corners
    function automatic q_t pick_q(input int unsigned span);
        q_t value;
        case ($urandom_range(0, 9))
            0: value = q_t'($urandom);
            1:
            begin
                case ($urandom_range(0, 4))
                    0: value = Q_MIN;
                    1: value = Q_MAX;
                    2: value = '0;
                    3: value = '1;
                    default: value = 32'sd1;
                endcase
            end
            default: value = q_t'(int'($urandom_range(0, 2 * span)) - int'(span));
        endcase
        return value;
    endfunction

    function automatic ufix_t pick_radius();
        ufix_t value;
        case ($urandom_range(0, 9))
            0: value = ufix_t'($urandom);
            1: value = $urandom_range(0, 1) ? R_MAX : '0;
            default: value = ufix_t'($urandom_range(0, 1 << 17));
        endcase
        return value;
    endfunction

    // indices cluster around the base/added boundary now and then
    function automatic int unsigned pick_index();
        int v;
        if ($urandom_range(0, 3) == 0)
        begin
            v = int'(base_now) + int'($urandom_range(0, 3)) - 2;
            if (v < 0)
                v = 0;
            if (v > IDX_MAX)
                v = IDX_MAX;
            return v;
        end
        return $urandom_range(0, IDX_MAX);
    endfunction

    function automatic contact_t random_contact();
        return mk_contact(pick_index(), pick_index(), pick_q(8192),
                          pick_q(65536), pick_q(65536), pick_q(1 << 18), pick_q(1 << 18),
                          pick_q(1 << 18), pick_q(1 << 18), pick_radius(), pick_radius(),
                          pick_q(1 << 20));
    endfunction

    // ------------------------------------------------------------------
    // configuration writes (block idle)
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned value,
                             input int width);
        logic [CFG_DATA_W-1:0] pad;
        logic [CFG_DATA_W-1:0] data;
        pad  = CFG_DATA_W'($urandom);
        data = CFG_DATA_W'(value);
        // junk above the register width must be dropped
        if (width < CFG_DATA_W)
            data = (pad << width)
                   | (data & ((CFG_DATA_W'(1) << width) - CFG_DATA_W'(1)));
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_NORMAL_STIFFNESS: kn_now = data[KN_W-1:0];
            CFG_STIFFNESS_FACTOR: cf_now = data[CF_W-1:0];
            CFG_BASE_COUNT:
            begin
                base_now = data[BASE_W-1:0];
                if (base_now > BASE_LIMIT)
                    base_now = BASE_LIMIT;
            end
            CFG_DAMPING:          damp_now = data;
            CFG_FRICTION_COEFF:   mu_now = data;
            CFG_TIME_STEP:        dt_now = data;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int unsigned kn, input int unsigned cf,
                                 input int unsigned base, input int unsigned damp,
                                 input int unsigned mu, input int unsigned dt);
        write_reg(CFG_NORMAL_STIFFNESS, kn, KN_W);
        write_reg(CFG_STIFFNESS_FACTOR, cf, CF_W);
        write_reg(CFG_BASE_COUNT, base, BASE_W);
        write_reg(CFG_DAMPING, damp, CFG_DATA_W);
        write_reg(CFG_FRICTION_COEFF, mu, CFG_DATA_W);
        write_reg(CFG_TIME_STEP, dt, CFG_DATA_W);
        write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom, CFG_DATA_W);
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // contact side
    // ------------------------------------------------------------------
    task automatic send_contact(input contact_t word, input bit typed, input result_t want);
        int unsigned gap;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
            gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap != 0)
        begin
            contact_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        contact       <= word;
        contact_valid <= 1'b1;
        @(posedge clk);
        while (!contact_ready)
            @(posedge clk);
        expected_forces.push_back(typed ? want : predict_contact_force(word));
    endtask

    task automatic run_random(input int count);
        repeat (count) send_contact(random_contact(), 1'b0, '0);
    endtask

    task automatic drain_results();
        contact_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_forces.size() != 0);
    endtask

    initial
    begin
        wait (rst_n);
        @(posedge clk);

        // reset configuration: both indices added, k = 10000
        directed_rows.push_back('{mk_contact(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                  1'b1, mk_result(0, 0, 0, 0, 0, 0, 1'b0)});
        directed_rows.push_back('{mk_contact(0, 0, -ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 0),
                                  1'b1, mk_result(32'sd655360000, 0, 32'sd655360000,
                                                  0, 0, 0, 1'b0)});
        directed_rows.push_back('{mk_contact(0, 0, Q_MIN, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                  1'b1, mk_result(Q_MAX, 0, 0, 0, 0, 0, 1'b0)});
        // discs apart: negative limit caps even a zero force
        directed_rows.push_back('{mk_contact(0, 0, Q_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                  1'b1, mk_result(Q_MIN, 32'sd1073741824, 0, 0, 0, 0,
                                                  1'b1)});
        directed_rows.push_back('{mk_contact(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, Q_MAX),
                                  1'b1, mk_result(0, 0, 0, 0, 0, 0, 1'b1)});
        directed_rows.push_back('{mk_contact(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, Q_MIN),
                                  1'b1, mk_result(0, 0, 0, 0, 0, 0, 1'b1)});
        directed_rows.push_back('{mk_contact(IDX_MAX, IDX_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                             Q_MAX, Q_MAX, Q_MAX, R_MAX, R_MAX, Q_MAX),
                                  1'b0, '0});
        directed_rows.push_back('{mk_contact(0, 0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                             Q_MIN, Q_MIN, 0, 0, Q_MIN),
                                  1'b0, '0});
        directed_rows.push_back('{mk_contact(IDX_MAX, 0, -1, -1, -1, -1, -1, -1, -1,
                                             R_MAX, R_MAX, -1),
                                  1'b0, '0});
        directed_rows.push_back('{mk_contact(1, 2, -ONE, ONE, 0, 0, 0, Q_MAX, 0,
                                             R_MAX, ONE, 0),
                                  1'b0, '0});
        directed_rows.push_back('{mk_contact(5, 9, -ONE, 0, ONE, 0, 0, 0, Q_MIN,
                                             ONE, R_MAX, 0),
                                  1'b0, '0});
        directed_rows.push_back('{mk_contact(3, 4, -655, 46341, 46341, ONE, -ONE, 0, 0,
                                             ONE, ONE, 1000),
                                  1'b0, '0});
        // tangent x saturates on the most negative normal y
        directed_rows.push_back('{mk_contact(0, IDX_MAX, -ONE, 0, Q_MIN, ONE, ONE, 0, 0,
                                             0, 0, 0),
                                  1'b0, '0});
        directed_rows.push_back('{mk_contact(7, 7, -6554, ONE, 0, 0, 100, 0, 0,
                                             ONE, ONE, 0),
                                  1'b0, '0});
        directed_rows.push_back('{mk_contact(7, 8, -655, 0, ONE, 4 * ONE, 0, ONE, -ONE,
                                             ONE, ONE, 32'sh1000_0000),
                                  1'b0, '0});
        directed_rows.push_back('{mk_contact(100, 200, -ONE, ONE, 0, Q_MIN, Q_MAX, Q_MAX,
                                             Q_MIN, ONE, ONE, Q_MIN),
                                  1'b0, '0});

        foreach (directed_rows[n])
            send_contact(directed_rows[n].word, directed_rows[n].typed, directed_rows[n].want);
        drain_results();

        // plausible material values, mixed base/added population
        apply_setting($urandom_range(100, 5000), $urandom_range(1, 20),
                      $urandom_range(0, BASE_LIMIT), $urandom_range(0, 10 * 65536),
                      $urandom_range(0, 65536), $urandom_range(1, 655));
        run_random(100);
        drain_results();

        // everything at its top; base count write gets clamped
        idle_on = 1'b0;
        apply_setting(16'hFFFF, 8'hFF, 15'h7FFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                      31'h7FFF_FFFF);
        run_random(60);
        drain_results();

        // bottom values but a normal stiffness of 1, zero stiffness factor
        idle_on = 1'b1;
        apply_setting(1, 0, 0, 0, 0, 0);
        run_random(60);
        drain_results();

        // full-range registers, base count 8192; fill the pipe while results are held off
        apply_setting($urandom_range(0, 16'hFFFF), $urandom_range(0, 8'hFF), 8192,
                      $urandom & 31'h7FFF_FFFF, $urandom & 31'h7FFF_FFFF,
                      $urandom & 31'h7FFF_FFFF);
        hold_pending = 1'b1;
        burst_left   = 40;
        run_random(100);
        drain_results();

        // zero normal stiffness
        apply_setting(0, $urandom_range(0, 8'hFF), $urandom_range(1, IDX_MAX),
                      $urandom_range(0, 65536), $urandom_range(0, 2 * 65536),
                      $urandom_range(0, 1000));
        run_random(60);
        drain_results();

        apply_setting($urandom_range(1, 16'hFFFF), $urandom_range(1, 8'hFF),
                      $urandom_range(0, BASE_LIMIT), $urandom_range(0, 65536),
                      $urandom_range(0, 65536), $urandom_range(0, 655));
        run_random(120);
        drain_results();

        repeat (3 * NUM_STAGES) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_pending)
            begin
                stall        = LONG_HOLD;
                hold_pending = 1'b0;
            end
            else
                stall = idle_on ? $urandom_range(0, 14) : 0;
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : score_results
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_forces.size() == 0)
            begin
                $error("result word with no contact outstanding");
                mismatch_count++;
            end
            else
            begin
                want = expected_forces.pop_front();
                check_field("normal_force", want.normal_force, result.normal_force);
                check_field("tangential_force", want.tangential_force,
                            result.tangential_force);
                check_field("force_x", want.force_x, result.force_x);
                check_field("force_y", want.force_y, result.force_y);
                check_field("torque_i", want.torque_i, result.torque_i);
                check_field("torque_j", want.torque_j, result.torque_j);
                check_field("slipping", 32'(want.slipping), 32'(result.slipping));
            end
        end
    end

    // no word moving on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (contact_valid && contact_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire

@@ files.f @@
src/dcf_pkg.sv
src/dcf_cfg.sv
src/dcf_pipe_ctrl.sv
src/dcf_datapath.sv
src/dem_contact_force_friction.sv
dv/testbench.sv
